>>> hdl/mtm_pkg.sv
`default_nettype none

package mtm_pkg;

  localparam int unsigned MEM_DEPTH_DEF  = 2048;
  localparam int unsigned PROG_DEPTH_DEF = 1024;
  localparam logic [31:0] STEP_LIMIT_RST = 32'd1000000;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_MUL   = 4'd1,
    OP_SUB   = 4'd2,
    OP_DIV   = 4'd3,
    OP_LT    = 4'd4,
    OP_GT    = 4'd5,
    OP_AND   = 4'd6,
    OP_OR    = 4'd7,
    OP_EQ    = 4'd8,
    OP_LDI   = 4'd9,
    OP_CPY   = 4'd10,
    OP_LDIND = 4'd11,
    OP_STIND = 4'd12,
    OP_JNE   = 4'd13,
    OP_JMP   = 4'd14,
    OP_NOP   = 4'd15
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_LIMIT   = 3'd1,
    ST_DIVZERO = 3'd2,
    ST_BADADDR = 3'd3,
    ST_BADJUMP = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         opcode;
    logic signed [31:0] arg_first;
    logic signed [31:0] arg_second;
    logic signed [31:0] arg_third;
    logic [9:0]         start_index;
    logic [10:0]        mem_address;
    logic signed [31:0] mem_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic [2:0]         status;
    logic [31:0]        steps_done;
    logic [10:0]        end_pc;
  } out_item_t;

  typedef struct packed {
    opcode_e     opcode;
    logic [31:0] arg_one;
    logic [31:0] arg_two;
    logic [31:0] arg_three;
  } instr_t;

  typedef struct packed {
    logic        valid;
    opcode_e     op;
    logic [31:0] x;
    logic [31:0] y;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

endpackage

`default_nettype wire

>>> hdl/mtm_chan_if.sv
`default_nettype none

interface mtm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/mtm_ram.sv
`default_nettype none

module mtm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

`default_nettype wire

>>> hdl/mtm_alu.sv
`default_nettype none

// Shared arithmetic unit: quick ops and a 32x32 multiply with registered result,
// radix-2 restoring divide (32 steps) on magnitudes.
module mtm_alu
  import mtm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire alu_req_t req_i,
  output alu_rsp_t      rsp_o
);
  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] quot_q, rem_q, dvs_q, res_q;
  logic        neg_q;

  logic [32:0] rem_sh, diff;
  logic [31:0] quot_nx, rem_nx, quick, mag_x, mag_y;

  always_comb begin
    rem_sh  = {rem_q, quot_q[31]};
    diff    = rem_sh - {1'b0, dvs_q};
    quot_nx = {quot_q[30:0], ~diff[32]};
    rem_nx  = diff[32] ? rem_sh[31:0] : diff[31:0];
    mag_x   = req_i.x[31] ? 32'd0 - req_i.x : req_i.x;
    mag_y   = req_i.y[31] ? 32'd0 - req_i.y : req_i.y;
    case (req_i.op)
      OP_ADD:  quick = req_i.x + req_i.y;
      OP_MUL:  quick = req_i.x * req_i.y;
      OP_SUB:  quick = req_i.x - req_i.y;
      OP_LT:   quick = {31'd0, $signed(req_i.x) < $signed(req_i.y)};
      OP_GT:   quick = {31'd0, $signed(req_i.y) < $signed(req_i.x)};
      OP_AND:  quick = {31'd0, (req_i.x != '0) && (req_i.y != '0)};
      OP_OR:   quick = {31'd0, (req_i.x != '0) || (req_i.y != '0)};
      OP_EQ:   quick = {31'd0, req_i.x == req_i.y};
      default: quick = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.valid) begin
        if (req_i.op == OP_DIV) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end else begin
          done_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      quot_q <= mag_x;
      rem_q  <= '0;
      dvs_q  <= mag_y;
      neg_q  <= req_i.x[31] ^ req_i.y[31];
      res_q  <= quick;
    end else if (busy_q) begin
      quot_q <= quot_nx;
      rem_q  <= rem_nx;
      if (cnt_q == 5'd31) begin
        res_q <= neg_q ? 32'd0 - quot_nx : quot_nx;
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;
endmodule

`default_nettype wire

>>> hdl/memory_to_memory_instruction_machine_core.sv
`default_nettype none

// Channel   Dir  Beat                          Handshake
// cfg       in   step_limit (32b)              cfg_we_i, no stall
// in_i      in   in_item_t (command)           valid/ready
// out_o     out  out_item_t (one per command)  valid/ready
//
// After reset the data store is swept to zero with in_i.ready low.
// Append/write: idle, then response; read adds a state for the registered RAM read.
// Run: fetch and decode per instruction; jump, nop, load immediate end there, copy
// and cond jump add an operand read, indirect ops a second read, compare/add/sub/mul
// an ALU state, divide the 32-step shared divider. The data RAM read port sets the pace.
// One command at a time; in_i.ready is high only while idle. A finished beat
// waits in the output register, so the next command is taken while out_o stalls.
module memory_to_memory_instruction_machine_core
  import mtm_pkg::*;
#(
  parameter int unsigned MEM_DEPTH  = MEM_DEPTH_DEF,
  parameter int unsigned PROG_DEPTH = PROG_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  mtm_chan_if.sink         in_i,
  mtm_chan_if.source       out_o
);
  localparam int unsigned MAW = $clog2(MEM_DEPTH);
  localparam int unsigned PAW = $clog2(PROG_DEPTH);
  localparam int unsigned PLW = PAW + 1;
  // pc must also hold any start index
  localparam int unsigned PCW = (PLW > 10) ? PLW : 10;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_READ   = 9'b000000100,
    S_FETCH  = 9'b000001000,
    S_DECODE = 9'b000010000,
    S_RDX    = 9'b000100000,
    S_RDY    = 9'b001000000,
    S_EXEC   = 9'b010000000,
    S_RESP   = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [MAW-1:0]  clr_q, clr_d;
  logic [PCW-1:0]  pc_q, pc_d;
  logic [PLW-1:0]  plen_q, plen_d;
  logic [31:0]     steps_q, steps_d;
  logic [31:0]     limit_q;
  logic            is_run_q, is_run_d;
  logic [2:0]      res_status_q, res_status_d;
  logic [31:0]     res_data_q, res_data_d;
  instr_t          ir_q, ir_d;
  logic [31:0]     x_q, x_d;
  logic [MAW-1:0]  t_q, t_d;
  logic            out_valid_q;
  out_item_t       out_item_q;
  logic            out_load;

  logic            dm_we;
  logic [MAW-1:0]  dm_waddr, dm_raddr;
  logic [31:0]     dm_wdata, dm_rdata;
  logic            pm_we;
  instr_t          pm_wdata, pm_rdata;

  alu_req_t        alu_req;
  alu_rsp_t        alu_rsp;

  in_item_t        cmd_item;

  function automatic logic addr_ok(input logic [31:0] a);
    return a < 32'(MEM_DEPTH);
  endfunction

  mtm_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .raddr_i (dm_raddr),
    .rdata_o (dm_rdata)
  );

  // program read address follows pc; data valid the cycle after pc settles
  mtm_ram #(.WIDTH($bits(instr_t)), .DEPTH(PROG_DEPTH)) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .waddr_i (plen_q[PAW-1:0]),
    .wdata_i (pm_wdata),
    .raddr_i (pc_q[PAW-1:0]),
    .rdata_o (pm_rdata)
  );

  mtm_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign cmd_item   = in_i.payload;
  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    pc_d         = pc_q;
    plen_d       = plen_q;
    steps_d      = steps_q;
    is_run_d     = is_run_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    ir_d         = ir_q;
    x_d          = x_q;
    t_d          = t_q;
    dm_we        = 1'b0;
    dm_waddr     = ir_q.arg_one[MAW-1:0];
    dm_wdata     = dm_rdata;
    dm_raddr     = '0;
    pm_we        = 1'b0;
    pm_wdata     = '{opcode_e'(cmd_item.opcode), cmd_item.arg_first,
                     cmd_item.arg_second, cmd_item.arg_third};
    alu_req      = '{1'b0, ir_q.opcode, x_q, dm_rdata};
    out_load     = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        dm_we    = 1'b1;
        dm_waddr = clr_q;
        dm_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == MAW'(MEM_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_i.valid) begin
          res_status_d = ST_OK;
          res_data_d   = '0;
          is_run_d     = 1'b0;
          state_d      = S_RESP;
          unique case (cmd_e'(cmd_item.cmd))
            CMD_APPEND: begin
              if (plen_q == PLW'(PROG_DEPTH)) begin
                res_status_d = ST_FULL;
              end else begin
                pm_we  = 1'b1;
                plen_d = plen_q + 1'b1;
              end
            end
            CMD_WRITE: begin
              if (addr_ok(32'(cmd_item.mem_address))) begin
                dm_we    = 1'b1;
                dm_waddr = MAW'(cmd_item.mem_address);
                dm_wdata = cmd_item.mem_value;
              end else begin
                res_status_d = ST_BADADDR;
              end
            end
            CMD_READ: begin
              if (addr_ok(32'(cmd_item.mem_address))) begin
                dm_raddr = MAW'(cmd_item.mem_address);
                state_d  = S_READ;
              end else begin
                res_status_d = ST_BADADDR;
              end
            end
            CMD_RUN: begin
              pc_d     = PCW'(cmd_item.start_index);
              steps_d  = '0;
              is_run_d = 1'b1;
              state_d  = S_FETCH;
            end
          endcase
        end
      end

      S_READ: begin
        res_data_d = dm_rdata;
        state_d    = S_RESP;
      end

      S_FETCH: begin
        if (pc_q >= PCW'(plen_q)) begin
          // ran off the program end: normal finish
          res_status_d = ST_OK;
          state_d      = S_RESP;
        end else if (steps_q == limit_q) begin
          res_status_d = ST_LIMIT;
          state_d      = S_RESP;
        end else begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        ir_d = pm_rdata;
        // default: failing instruction leaves pc and step count alone
        res_status_d = ST_BADADDR;
        state_d      = S_RESP;
        case (pm_rdata.opcode) inside
          [OP_ADD:OP_EQ]: begin
            if (addr_ok(pm_rdata.arg_one) && addr_ok(pm_rdata.arg_two) &&
                addr_ok(pm_rdata.arg_three)) begin
              dm_raddr = pm_rdata.arg_two[MAW-1:0];
              state_d  = S_RDX;
            end
          end
          OP_LDI: begin
            if (addr_ok(pm_rdata.arg_one)) begin
              dm_we    = 1'b1;
              dm_waddr = pm_rdata.arg_one[MAW-1:0];
              dm_wdata = pm_rdata.arg_two;
              pc_d     = pc_q + 1'b1;
              steps_d  = steps_q + 32'd1;
              state_d  = S_FETCH;
            end
          end
          OP_CPY, OP_LDIND: begin
            if (addr_ok(pm_rdata.arg_one) && addr_ok(pm_rdata.arg_two)) begin
              dm_raddr = pm_rdata.arg_two[MAW-1:0];
              state_d  = S_RDX;
            end
          end
          OP_STIND: begin
            if (addr_ok(pm_rdata.arg_one) && addr_ok(pm_rdata.arg_two)) begin
              dm_raddr = pm_rdata.arg_one[MAW-1:0];
              state_d  = S_RDX;
            end
          end
          OP_JNE: begin
            if (addr_ok(pm_rdata.arg_one)) begin
              dm_raddr = pm_rdata.arg_one[MAW-1:0];
              state_d  = S_RDX;
            end
          end
          OP_JMP: begin
            if (pm_rdata.arg_one > 32'(plen_q)) begin
              res_status_d = ST_BADJUMP;
            end else begin
              pc_d    = PCW'(pm_rdata.arg_one);
              steps_d = steps_q + 32'd1;
              state_d = S_FETCH;
            end
          end
          default: begin
            pc_d    = pc_q + 1'b1;
            steps_d = steps_q + 32'd1;
            state_d = S_FETCH;
          end
        endcase
      end

      S_RDX: begin
        x_d = dm_rdata;
        case (ir_q.opcode) inside
          OP_CPY: begin
            dm_we   = 1'b1;
            pc_d    = pc_q + 1'b1;
            steps_d = steps_q + 32'd1;
            state_d = S_FETCH;
          end
          OP_LDIND: begin
            if (addr_ok(dm_rdata)) begin
              dm_raddr = dm_rdata[MAW-1:0];
              state_d  = S_RDY;
            end else begin
              res_status_d = ST_BADADDR;
              state_d      = S_RESP;
            end
          end
          OP_STIND: begin
            if (addr_ok(dm_rdata)) begin
              t_d      = dm_rdata[MAW-1:0];
              dm_raddr = ir_q.arg_two[MAW-1:0];
              state_d  = S_RDY;
            end else begin
              res_status_d = ST_BADADDR;
              state_d      = S_RESP;
            end
          end
          OP_JNE: begin
            if (dm_rdata != 32'd1) begin
              if (ir_q.arg_two > 32'(plen_q)) begin
                res_status_d = ST_BADJUMP;
                state_d      = S_RESP;
              end else begin
                pc_d    = PCW'(ir_q.arg_two);
                steps_d = steps_q + 32'd1;
                state_d = S_FETCH;
              end
            end else begin
              pc_d    = pc_q + 1'b1;
              steps_d = steps_q + 32'd1;
              state_d = S_FETCH;
            end
          end
          default: begin
            // two-operand ops fetch the second source
            dm_raddr = ir_q.arg_three[MAW-1:0];
            state_d  = S_RDY;
          end
        endcase
      end

      S_RDY: begin
        case (ir_q.opcode) inside
          OP_LDIND, OP_STIND: begin
            dm_we = 1'b1;
            if (ir_q.opcode == OP_STIND) begin
              dm_waddr = t_q;
            end
            pc_d    = pc_q + 1'b1;
            steps_d = steps_q + 32'd1;
            state_d = S_FETCH;
          end
          default: begin
            if (ir_q.opcode == OP_DIV && dm_rdata == '0) begin
              res_status_d = ST_DIVZERO;
              state_d      = S_RESP;
            end else begin
              alu_req.valid = 1'b1;
              state_d       = S_EXEC;
            end
          end
        endcase
      end

      S_EXEC: begin
        if (alu_rsp.done) begin
          dm_we    = 1'b1;
          dm_wdata = alu_rsp.result;
          pc_d     = pc_q + 1'b1;
          steps_d  = steps_q + 32'd1;
          state_d  = S_FETCH;
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pc_q        <= '0;
      plen_q      <= '0;
      steps_q     <= '0;
      is_run_q    <= 1'b0;
      limit_q     <= STEP_LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      pc_q     <= pc_d;
      plen_q   <= plen_d;
      steps_q  <= steps_d;
      is_run_q <= is_run_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    ir_q         <= ir_d;
    x_q          <= x_d;
    t_q          <= t_d;
    if (out_load) begin
      out_item_q.read_data  <= res_data_q;
      out_item_q.status     <= res_status_q;
      out_item_q.steps_done <= is_run_q ? steps_q : 32'd0;
      out_item_q.end_pc     <= is_run_q ? 11'(pc_q) : 11'd0;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  a_no_cmd_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_i.ready)
    else $error("command taken during data store sweep");

  a_steps_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |-> (steps_q <= limit_q))
    else $error("step count passed the limit");

  a_plen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= PLW'(PROG_DEPTH))
    else $error("program length beyond store depth");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result beat raised outside the response state");

endmodule

`default_nettype wire

>>> bench/memory_to_memory_instruction_machine_core_test.sv
module memory_to_memory_instruction_machine_core_test;
  import mtm_pkg::*;

  localparam int unsigned MEMD  = MEM_DEPTH_DEF;
  localparam int unsigned PROGD = PROG_DEPTH_DEF;
  localparam int unsigned IDLE_LIMIT = 500000;
  // keeps looping programs short
  localparam logic [31:0] RUN_LIMIT = 32'd2000;

  // Golden interpreter: mirrors the block's stores and runs each command.
  class machine_scoreboard;
    logic [31:0] dmem [MEMD];
    logic [3:0]  p_op [PROGD];
    logic [31:0] p_a1 [PROGD];
    logic [31:0] p_a2 [PROGD];
    logic [31:0] p_a3 [PROGD];
    int unsigned prog_len;
    logic [31:0] limit;
    out_item_t   pending[$];
    int          errors;

    function void clear();
      foreach (dmem[i]) dmem[i] = '0;
      prog_len = 0;
      limit = STEP_LIMIT_RST;
      pending.delete();
      errors = 0;
    endfunction

    function bit addr_ok(logic [31:0] a);
      return a < MEMD;
    endfunction

    function logic [31:0] quot(logic [31:0] x, logic [31:0] y);
      logic [31:0] mx, my, q;
      mx = x[31] ? -x : x;
      my = y[31] ? -y : y;
      q = mx / my;
      return (x[31] != y[31]) ? -q : q;
    endfunction

    // One instruction at pc; returns status, updates pc on success.
    function status_e exec(ref logic [31:0] pc);
      logic [3:0] op;
      logic [31:0] a1, a2, a3, x, y, r, t;
      op = p_op[pc]; a1 = p_a1[pc]; a2 = p_a2[pc]; a3 = p_a3[pc];
      if (op <= OP_EQ) begin
        if (!addr_ok(a1) || !addr_ok(a2) || !addr_ok(a3)) return ST_BADADDR;
        x = dmem[a2]; y = dmem[a3];
        case (opcode_e'(op))
          OP_ADD: r = x + y;
          OP_MUL: r = x * y;
          OP_SUB: r = x - y;
          OP_DIV: begin
            if (y == 0) return ST_DIVZERO;
            r = quot(x, y);
          end
          OP_LT:  r = ($signed(x) < $signed(y)) ? 1 : 0;
          OP_GT:  r = ($signed(y) < $signed(x)) ? 1 : 0;
          OP_AND: r = (x != 0 && y != 0) ? 1 : 0;
          OP_OR:  r = (x != 0 || y != 0) ? 1 : 0;
          default: r = (x == y) ? 1 : 0;
        endcase
        dmem[a1] = r;
        pc++;
        return ST_OK;
      end
      case (opcode_e'(op))
        OP_LDI: begin
          if (!addr_ok(a1)) return ST_BADADDR;
          dmem[a1] = a2;
        end
        OP_CPY: begin
          if (!addr_ok(a1) || !addr_ok(a2)) return ST_BADADDR;
          dmem[a1] = dmem[a2];
        end
        OP_LDIND: begin
          if (!addr_ok(a1) || !addr_ok(a2)) return ST_BADADDR;
          t = dmem[a2];
          if (!addr_ok(t)) return ST_BADADDR;
          dmem[a1] = dmem[t];
        end
        OP_STIND: begin
          if (!addr_ok(a1) || !addr_ok(a2)) return ST_BADADDR;
          t = dmem[a1];
          if (!addr_ok(t)) return ST_BADADDR;
          dmem[t] = dmem[a2];
        end
        OP_JNE: begin
          if (!addr_ok(a1)) return ST_BADADDR;
          if (dmem[a1] != 1) begin
            if (a2 > prog_len) return ST_BADJUMP;
            pc = a2;
            return ST_OK;
          end
        end
        OP_JMP: begin
          if (a1 > prog_len) return ST_BADJUMP;
          pc = a1;
          return ST_OK;
        end
        default: ;
      endcase
      pc++;
      return ST_OK;
    endfunction

    function void note_command(in_item_t c);
      out_item_t o;
      logic [31:0] pc, steps;
      status_e st;
      o = '0;
      st = ST_OK;
      case (cmd_e'(c.cmd))
        CMD_APPEND: begin
          if (prog_len >= PROGD) st = ST_FULL;
          else begin
            p_op[prog_len] = c.opcode; p_a1[prog_len] = c.arg_first;
            p_a2[prog_len] = c.arg_second; p_a3[prog_len] = c.arg_third;
            prog_len++;
          end
        end
        CMD_WRITE: begin
          if (addr_ok(c.mem_address)) dmem[c.mem_address] = c.mem_value;
          else st = ST_BADADDR;
        end
        CMD_READ: begin
          if (addr_ok(c.mem_address)) o.read_data = dmem[c.mem_address];
          else st = ST_BADADDR;
        end
        default: begin
          pc = c.start_index;
          steps = 0;
          while (pc < prog_len) begin
            if (steps == limit) begin
              st = ST_LIMIT;
              break;
            end
            st = exec(pc);
            if (st != ST_OK) break;
            steps++;
          end
          o.steps_done = steps;
          o.end_pc = pc[10:0];
        end
      endcase
      o.status = st;
      pending.push_back(o);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    task check_result(out_item_t g);
      out_item_t w;
      if (pending.size() == 0) begin
        report("unexpected beat", 0, 0);
        return;
      end
      w = pending.pop_front();
      if (g.read_data  !== w.read_data)  report("read_data", g.read_data, w.read_data);
      if (g.status     !== w.status)     report("status", g.status, w.status);
      if (g.steps_done !== w.steps_done) report("steps_done", g.steps_done, w.steps_done);
      if (g.end_pc     !== w.end_pc)     report("end_pc", g.end_pc, w.end_pc);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [31:0] cfg_wdata_i = '0;

  mtm_chan_if #(.payload_t(in_item_t))  cmd_ch ();
  mtm_chan_if #(.payload_t(out_item_t)) res_ch ();

  memory_to_memory_instruction_machine_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_i(cmd_ch.sink), .out_o(res_ch.source)
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  machine_scoreboard sb = new();
  int unsigned idle_cycles;
  int unsigned hold_cycles;
  bit stall_ok;

  initial begin
    cmd_ch.valid = 0;
    cmd_ch.payload = '0;
    res_ch.ready = 0;
  end

  // Result side: random backpressure with rare long holds, check each beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.payload);
      if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
        res_ch.ready <= 0;
      end else if (stall_ok && $urandom_range(0, 99) < 2) begin
        hold_cycles <= $urandom_range(10, 60);
        res_ch.ready <= 0;
      end else begin
        res_ch.ready <= !stall_ok || ($urandom_range(0, 99) < 70);
      end
    end
  end

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("** memory_to_memory_instruction_machine_core: FAILED **");
      $finish;
    end
  end

  // Mostly short gaps, occasionally a long one, sometimes none.
  function int gap_len();
    int n;
    n = $urandom_range(0, 99);
    if (n < 40) n = 0;
    else if (n < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    return n;
  endfunction

  // valid stays high across back-to-back beats; it drops only for a gap
  task send(in_item_t c);
    int n;
    n = stall_ok ? gap_len() : 0;
    if (n != 0) begin
      cmd_ch.valid <= 0;
      repeat (n) @(posedge clk_i);
    end
    cmd_ch.valid <= 1;
    cmd_ch.payload <= c;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    sb.note_command(c);
  endtask

  // Wait until the scoreboard is empty and the block is quiet.
  task drain();
    cmd_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task set_limit(logic [31:0] v);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.limit = v;
    @(posedge clk_i);
  endtask

  function in_item_t mk(cmd_e c);
    in_item_t t;
    t = '0;
    t.cmd = c;
    return t;
  endfunction

  task append(opcode_e op, logic [31:0] a1, logic [31:0] a2, logic [31:0] a3);
    in_item_t t;
    t = mk(CMD_APPEND);
    t.opcode = op; t.arg_first = a1; t.arg_second = a2; t.arg_third = a3;
    send(t);
  endtask

  task wr(logic [10:0] a, logic [31:0] v);
    in_item_t t;
    t = mk(CMD_WRITE);
    t.mem_address = a; t.mem_value = v;
    send(t);
  endtask

  task rd(logic [10:0] a);
    in_item_t t;
    t = mk(CMD_READ);
    t.mem_address = a;
    send(t);
  endtask

  task run(logic [9:0] s);
    in_item_t t;
    t = mk(CMD_RUN);
    t.start_index = s;
    send(t);
  endtask

  // Mostly small in-range addresses so runs get deep; sometimes any value.
  function logic [31:0] pick_addr();
    int n;
    n = $urandom_range(0, 99);
    if (n < 85) return $urandom_range(0, 15);
    if (n < 93) return $urandom_range(0, MEMD - 1);
    if (n < 97) return MEMD;
    return $urandom;
  endfunction

  function logic [31:0] pick_value();
    int n;
    n = $urandom_range(0, 9);
    case (n)
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 0;
      3: return 1;
      4, 5: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  int sent;
  in_item_t junk;

  initial begin
    sb.clear();
    stall_ok = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: data commands at extreme values and the top address.
    wr(11'd0, 32'h7FFF_FFFF);
    wr(11'd1, 32'h8000_0000);
    wr(11'd2, 32'hFFFF_FFFF);
    wr(11'(MEMD - 1), 32'hA5A5_5A5A);
    wr(11'h7FF, 32'h1234_5678);
    rd(11'(MEMD - 1));
    rd(11'h7FF);
    // Run on an empty program: start past program end.
    run(10'h3FF);
    // Division edge: most negative by minus one; divide by zero.
    append(OP_DIV, 3, 1, 2);
    append(OP_DIV, 4, 1, 5);
    run(10'd0);
    run(10'd1);
    rd(11'd3);
    // Jumps past the program end are bad targets.
    append(OP_JMP, 5, 0, 0);
    append(OP_JMP, 32'hFFFF_FFFF, 0, 0);
    run(10'd2);
    run(10'd3);
    append(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    append(OP_LDI, 32'h8000_0000, 0, 0);
    run(10'd4);
    run(10'd5);
    // Step limit of zero stops before the first instruction; one allows one.
    set_limit(0);
    run(10'd4);
    set_limit(1);
    run(10'd4);
    set_limit(32'hFFFF_FFFF);
    run(10'd4);
    set_limit(RUN_LIMIT);
    drain();

    // Random phase: short programs separated by data traffic and runs.
    stall_ok = 1;
    sent = 0;
    while (sent < 920) begin
      int k, base;
      k = $urandom_range(0, 99);
      if (k < 40 && sb.prog_len < PROGD - 8) begin
        opcode_e op;
        op = opcode_e'($urandom_range(0, 15));
        base = sb.prog_len;
        if (op == OP_JNE)
          append(op, pick_addr(), $urandom_range(0, 99) < 90 ?
                 $urandom_range(0, base + 2) : $urandom, pick_addr());
        else if (op == OP_JMP)
          // Mostly forward jumps so runs terminate.
          append(op, $urandom_range(0, 99) < 90 ? base + $urandom_range(1, 2) :
                 $urandom, pick_addr(), pick_addr());
        else if (op == OP_LDI)
          append(op, pick_addr(), pick_value(), pick_value());
        else
          append(op, pick_addr(), pick_addr(), pick_addr());
      end else if (k < 60) wr(11'(pick_addr()), pick_value());
      else if (k < 75) rd(11'($urandom_range(0, 99) < 90 ? pick_addr() : $urandom));
      else if (k < 92) begin
        run(10'(sb.prog_len == 0 ? 0 :
            ($urandom_range(0, 9) < 8 ? $urandom_range(0, sb.prog_len - 1) : $urandom)));
      end else begin
        // Odd commands with every field random.
        junk = $bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom});
        send(junk);
      end
      sent++;
      if (sent == 300) begin
        drain();
        set_limit($urandom_range(2, 40));
      end
      if (sent == 600) set_limit(RUN_LIMIT);
      if (sent == 450) drain();
    end

    append(OP_ADD, 0, 0, 0);
    set_limit(7);
    run(10'd0);
    run(10'(PROGD - 3));

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** memory_to_memory_instruction_machine_core: PASSED **");
    end else begin
      $display("** memory_to_memory_instruction_machine_core: FAILED **");
    end
    $finish;
  end
endmodule

>>> filelist.f
hdl/mtm_pkg.sv
hdl/mtm_chan_if.sv
hdl/mtm_ram.sv
hdl/mtm_alu.sv
hdl/memory_to_memory_instruction_machine_core.sv
bench/memory_to_memory_instruction_machine_core_test.sv
